@@ hw/rtl/primary_ray_generator_core_defines.svh @@
// assertion helpers for the primary ray generator
`ifndef PRIMARY_RAY_GENERATOR_CORE_DEFINES_SVH
`define PRIMARY_RAY_GENERATOR_CORE_DEFINES_SVH

`define PRG_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");

`define PRG_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");

`endif

@@ hw/rtl/prg_pkg.sv @@
`default_nettype none
package prg_pkg;

  localparam int unsigned RegW = 48;
  localparam int unsigned IdxW = 3;

  localparam logic [IdxW-1:0] REG_ORIGIN = 3'd0;
  localparam logic [IdxW-1:0] REG_VIEW   = 3'd1;
  localparam logic [IdxW-1:0] REG_RIGHT  = 3'd2;
  localparam logic [IdxW-1:0] REG_UP     = 3'd3;
  localparam logic [IdxW-1:0] REG_DIST   = 3'd4;
  localparam logic [IdxW-1:0] REG_PITCH  = 3'd5;
  localparam logic [IdxW-1:0] REG_WIDTH  = 3'd6;
  localparam logic [IdxW-1:0] REG_HEIGHT = 3'd7;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               zero_length;
  } ray_t;

endpackage
`default_nettype wire

@@ hw/rtl/prg_if.sv @@
`default_nettype none
interface prg_if #(
  parameter type word_t = logic
) (
  input wire logic clk
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/prg_isqrt.sv @@
`default_nettype none
// pipelined integer square root, 62-bit radicand, two result bits a stage
module prg_isqrt
  import prg_pkg::*;
#(
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [61:0]     radicand,
  input  wire logic [TagW-1:0] in_tag,
  output logic                 out_valid,
  output logic [30:0]          root,
  output logic [TagW-1:0]      out_tag
);
  localparam int unsigned Steps = 31;
  localparam int unsigned Stages = 16;

  logic [Stages:0]           vld;
  logic [63:0]               rem  [Stages+1];
  logic [31:0]               res  [Stages+1];
  logic [TagW-1:0]           tag  [Stages+1];

  assign vld[0] = in_valid;
  assign rem[0] = {2'b00, radicand};
  assign res[0] = '0;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [63:0] r_c;
    logic [31:0] q_c;
    always_comb begin
      logic [63:0] trial;
      r_c = rem[s];
      q_c = res[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < Steps) begin
          trial = {q_c, 2'b01} << (2 * (Steps - 1 - (2 * s + j)));
          if (r_c >= trial) begin
            r_c = r_c - trial;
            q_c = {q_c[30:0], 1'b1};
          end else begin
            q_c = {q_c[30:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1] <= r_c;
        res[s+1] <= q_c;
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[Stages];
  assign root      = res[Stages][30:0];
  assign out_tag   = tag[Stages];
endmodule
`default_nettype wire

@@ hw/rtl/prg_qdiv.sv @@
`default_nettype none
// pipelined restoring divider: (floor(num / den) + 1) / 2, 46-bit numerator, two bits a stage
module prg_qdiv
  import prg_pkg::*;
#(
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [45:0]     num,
  input  wire logic [30:0]     den,
  input  wire logic [TagW-1:0] in_tag,
  output logic                 out_valid,
  output logic [15:0]          quot,
  output logic [TagW-1:0]      out_tag
);
  localparam int unsigned QW = 17;
  localparam int unsigned Stages = 9;

  logic [Stages:0]  vld;
  logic [45:0]      nrm [Stages+1];
  logic [31:0]      pr  [Stages+1];
  logic [QW-1:0]    q   [Stages+1];
  logic [30:0]      dv  [Stages+1];
  logic [TagW-1:0]  tag [Stages+1];

  // quotient is below 2^17, so the top 29 numerator bits already sit below den
  assign vld[0] = in_valid;
  assign pr[0]  = {3'b000, num[45:17]};
  assign nrm[0] = {num[16:0], 29'd0};
  assign q[0]   = '0;
  assign dv[0]  = den;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [31:0] p_c;
    logic [45:0] n_c;
    logic [QW-1:0] q_c;
    always_comb begin
      p_c = pr[s];
      n_c = nrm[s];
      q_c = q[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < QW) begin
          p_c = {p_c[30:0], n_c[45]};
          n_c = {n_c[44:0], 1'b0};
          if (p_c >= {1'b0, dv[s]}) begin
            p_c = p_c - {1'b0, dv[s]};
            q_c = {q_c[QW-2:0], 1'b1};
          end else begin
            q_c = {q_c[QW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        pr[s+1]  <= p_c;
        nrm[s+1] <= n_c;
        q[s+1]   <= q_c;
        dv[s+1]  <= dv[s];
        tag[s+1] <= tag[s];
      end
    end
  end

  logic [QW:0] rnd;
  assign rnd       = {1'b0, q[Stages]} + 1'b1;
  assign out_valid = vld[Stages];
  assign quot      = rnd[16:1];
  assign out_tag   = tag[Stages];
endmodule
`default_nettype wire

@@ hw/rtl/primary_ray_generator_core.sv @@
// Pinhole camera ray generator. Each pixel word (column, row) yields one ray word: the
// configured origin and the unit direction of the view vector through the pixel center,
// signed Q1.14, rounded half away from zero; a zero view vector gives a zero direction
// with zero_length set. One pixel enters every cycle unless the output stalls; the pipe
// holds the multiply stages, a 16-stage square root and a 9-stage divider. The user must
// write configuration only while no pixel is in flight; the block does not enforce it.
`default_nettype none
module primary_ray_generator_core
  import prg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [IdxW-1:0]    cfg_index,
  input  wire logic [RegW-1:0]    cfg_data,
  prg_if.sink                     pix,
  prg_if.source                   ray
);
`include "primary_ray_generator_core_defines.svh"

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);

  logic [47:0] origin_packed, view_dir, right_dir, up_dir;
  logic [23:0] plane_dist, pixel_pitch;
  logic [12:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_packed <= '0;
      view_dir      <= '0;
      right_dir     <= '0;
      up_dir        <= '0;
      plane_dist    <= 24'd4096;
      pixel_pitch   <= '0;
      image_width   <= 13'd640;
      image_height  <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN: origin_packed <= cfg_data;
        REG_VIEW:   view_dir      <= cfg_data;
        REG_RIGHT:  right_dir     <= cfg_data;
        REG_UP:     up_dir        <= cfg_data;
        REG_DIST:   plane_dist    <= cfg_data[23:0];
        REG_PITCH:  pixel_pitch   <= cfg_data[23:0];
        REG_WIDTH:  image_width   <= cfg_data[12:0];
        REG_HEIGHT: image_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // pipeline enable: whole pipe advances when output slot is free or empty
  logic en;
  logic out_v;
  assign en        = !out_v || ray.ready;
  assign pix.ready = en;

  // stage 1: half-pixel offsets
  logic        v1;
  logic signed [14:0] hx1, hy1;
  logic [DimW-1:0] w_sat, h_sat;
  logic signed [14:0] hx_c, hy_c;
  always_comb begin
    w_sat = (32'(image_width) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(image_width);
    h_sat = (32'(image_height) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(image_height);
    hx_c = $signed({2'b00, pix.data.pixel_col, 1'b1}) - $signed(15'(w_sat));
    hy_c = $signed(15'(h_sat)) - $signed({2'b00, pix.data.pixel_row, 1'b1});
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= pix.valid;
    if (en) begin
      hx1 <= hx_c;
      hy1 <= hy_c;
    end
  end

  // stage 2: pitch products, and the distance term
  logic v2;
  logic signed [39:0] ax2, ay2;
  logic signed [33:0] dist2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      ax2   <= $signed({1'b0, pixel_pitch}) * hx1;
      ay2   <= $signed({1'b0, pixel_pitch}) * hy1;
      dist2 <= $signed({1'b0, plane_dist, 9'd0});
    end
  end

  // stage 3: per-lane products
  logic v3;
  logic signed [55:0] pv3 [3], pr3 [3], pu3 [3];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pv3[k] <= $signed(view_dir[16*k +: 16]) * dist2;
        pr3[k] <= $signed(right_dir[16*k +: 16]) * ax2;
        pu3[k] <= $signed(up_dir[16*k +: 16]) * ay2;
      end
    end
  end

  // stage 4: sum, sign and magnitude
  logic v4;
  logic [56:0] mag4 [3];
  logic [2:0]  neg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [57:0] s;
        s = 58'(pv3[k]) + 58'(pr3[k]) + 58'(pu3[k]);
        neg4[k] <= s[57];
        mag4[k] <= s[57] ? 57'(-s) : 57'(s);
      end
    end
  end

  // stage 5: bit length of the largest magnitude
  logic v5;
  logic [56:0] mag5 [3];
  logic [2:0]  neg5;
  logic [5:0]  n5;
  logic        z5;
  logic [56:0] m_c;
  logic [5:0]  n_c;
  always_comb begin
    m_c = mag4[0] | mag4[1] | mag4[2];
    n_c = '0;
    for (int b = 0; b < 57; b++) begin
      if (m_c[b]) n_c = 6'(b + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      mag5 <= mag4;
      neg5 <= neg4;
      n5   <= n_c;
      z5   <= (m_c == '0);
    end
  end

  // stage 6: normalize so the largest magnitude sits in [2^29, 2^30)
  logic v6;
  logic [29:0] c6 [3];
  logic [2:0]  neg6;
  logic        z6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (n5 > 6'd30) c6[k] <= 30'(mag5[k] >> (n5 - 6'd30));
        else c6[k] <= 30'(mag5[k] << (6'd30 - n5));
      end
      neg6 <= neg5;
      z6   <= z5;
    end
  end

  // stage 7: squares
  logic v7;
  logic [59:0] sq7 [3];
  logic [29:0] c7 [3];
  logic [2:0]  neg7;
  logic        z7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      for (int k = 0; k < 3; k++) sq7[k] <= c6[k] * c6[k];
      c7   <= c6;
      neg7 <= neg6;
      z7   <= z6;
    end
  end

  // stage 8: sum of squares
  logic v8;
  logic [61:0] l8;
  logic [29:0] c8 [3];
  logic [2:0]  neg8;
  logic        z8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      l8   <= 62'(sq7[0]) + 62'(sq7[1]) + 62'(sq7[2]);
      c8   <= c7;
      neg8 <= neg7;
      z8   <= z7;
    end
  end

  localparam int unsigned TagW = 94;
  logic [TagW-1:0] sq_tag_in, sq_tag_out;
  logic            v9;
  logic [30:0]     r9;
  assign sq_tag_in = {c8[0], c8[1], c8[2], neg8, z8};

  prg_isqrt #(.TagW(TagW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v8), .radicand(l8), .in_tag(sq_tag_in),
    .out_valid(v9), .root(r9), .out_tag(sq_tag_out)
  );

  logic [29:0] c9 [3];
  logic [2:0]  neg9;
  logic        z9;
  assign {c9[0], c9[1], c9[2], neg9, z9} = sq_tag_out;
  // a zero vector gives a zero root; feed a nonzero divisor and mask later
  logic [30:0] den9;
  assign den9 = z9 ? 31'd1 : r9;

  logic [2:0]  dv_v;
  logic [15:0] q10 [3];
  logic [3:0]  dtag [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    prg_qdiv #(.TagW(4)) u_div (
      .clk(clk), .rst(rst), .en(en), .in_valid(v9),
      .num({1'b0, c9[k], 15'd0}), .den(den9), .in_tag({neg9, z9}),
      .out_valid(dv_v[k]), .quot(q10[k]), .out_tag(dtag[k])
    );
  end

  logic [2:0] neg10;
  logic       z10;
  assign neg10 = dtag[0][3:1];
  assign z10   = dtag[0][0];

  ray_t res_c;
  ray_t res_q;
  always_comb begin
    res_c.origin_x    = origin_packed[15:0];
    res_c.origin_y    = origin_packed[31:16];
    res_c.origin_z    = origin_packed[47:32];
    res_c.dir_x       = z10 ? '0 : (neg10[0] ? -q10[0] : q10[0]);
    res_c.dir_y       = z10 ? '0 : (neg10[1] ? -q10[1] : q10[1]);
    res_c.dir_z       = z10 ? '0 : (neg10[2] ? -q10[2] : q10[2]);
    res_c.zero_length = z10;
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= dv_v[0];
    if (en) res_q <= res_c;
  end

  assign ray.valid = out_v;
  assign ray.data  = res_q;

  `PRG_ASSERT_IMP(a_lanes_aligned, clk, rst, 1'b1, dv_v == {3{dv_v[0]}})
  `PRG_ASSERT_IMP(a_zero_dir, clk, rst, out_v && res_q.zero_length,
                  res_q.dir_x == 16'sd0 && res_q.dir_y == 16'sd0 && res_q.dir_z == 16'sd0)
  `PRG_ASSERT_NEXT(a_hold, clk, rst, out_v && !ray.ready, out_v && $stable(res_q))
  `PRG_ASSERT_IMP(a_unit_bound, clk, rst, out_v,
                  res_q.dir_x <= 16'sd16384 && res_q.dir_x >= -16'sd16384)
endmodule
`default_nettype wire

@@ verif/tb_primary_ray_generator_core.sv @@
`default_nettype none
module tb_primary_ray_generator_core;
  import prg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim = 4096;
  localparam int Latency = 40;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [RegW-1:0] cfg_data;

  prg_if #(.word_t(pix_t)) pix (.clk(clk));
  prg_if #(.word_t(ray_t)) ray (.clk(clk));

  primary_ray_generator_core #(.MAX_DIM(MaxDim)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix(pix.sink),
    .ray(ray.source)
  );

  // camera setup as the block should hold it
  logic [47:0] cam_origin, cam_view, cam_right, cam_up;
  logic [23:0] cam_dist, cam_pitch;
  logic [12:0] cam_width, cam_height;

  pix_t pending_pix[$];
  ray_t expected_rays[$];
  int errors = 0;
  int rays_seen = 0;
  int zero_rays = 0;
  int pix_gap = 0;
  int ray_stall = 0;
  logic pix_acc = 1'b0;
  logic ray_acc = 1'b0;
  bit hold = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(pix_t p);
    ray_t r;
    longint w, h, hx, hy, ax, ay, dterm, vi;
    logic [63:0] mag[3];
    logic [63:0] m, sq, root, q;
    bit neg[3];
    int n;
    logic [15:0] d[3];
    w = (cam_width > MaxDim) ? MaxDim : longint'(cam_width);
    h = (cam_height > MaxDim) ? MaxDim : longint'(cam_height);
    hx = 2 * longint'(p.pixel_col) + 1 - w;
    hy = h - 2 * longint'(p.pixel_row) - 1;
    ax = longint'(cam_pitch) * hx;
    ay = longint'(cam_pitch) * hy;
    dterm = longint'(cam_dist) * 512;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      vi = longint'($signed(cam_view[16*k +: 16])) * dterm
         + longint'($signed(cam_right[16*k +: 16])) * ax
         + longint'($signed(cam_up[16*k +: 16])) * ay;
      neg[k] = vi < 0;
      mag[k] = neg[k] ? -vi : vi;
      if (mag[k] > m) m = mag[k];
    end
    r.origin_x = cam_origin[15:0];
    r.origin_y = cam_origin[31:16];
    r.origin_z = cam_origin[47:32];
    if (m == 0) begin
      r.dir_x = 0;
      r.dir_y = 0;
      r.dir_z = 0;
      r.zero_length = 1'b1;
      return r;
    end
    n = 0;
    while (m != 0) begin
      n++;
      m = m >> 1;
    end
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      if (n > 30) mag[k] = mag[k] >> (n - 30);
      else mag[k] = mag[k] << (30 - n);
      sq = sq + mag[k] * mag[k];
    end
    root = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 15) / root + 1) >> 1;
      d[k] = neg[k] ? -q[15:0] : q[15:0];
    end
    r.dir_x = d[0];
    r.dir_y = d[1];
    r.dir_z = d[2];
    r.zero_length = 1'b0;
    return r;
  endfunction

  // sender
  always @(posedge clk) pix_acc <= pix.valid && pix.ready;

  always @(negedge clk) begin
    int gap;
    gap = pix_gap;
    if (!rst && pix_acc) begin
      expected_rays.push_back(trace_ray(pending_pix.pop_front()));
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    end else if (gap > 0) begin
      gap--;
    end
    pix_gap <= gap;
    if (!rst && pix.valid && !pix_acc) begin
      // word still waiting: keep it on the bus
      pix.valid <= 1'b1;
    end else if (!rst && !hold && gap == 0 && pending_pix.size() > 0) begin
      pix.valid <= 1'b1;
      pix.data <= pending_pix[0];
    end else begin
      pix.valid <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    ray_t exp_ray;
    longint ev[7], av[7];
    string names[7];
    ray_acc <= ray.valid && ray.ready;
    if (!rst && ray.valid && ray.ready) begin
      rays_seen++;
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected ray word %p", $time, ray.data);
        errors++;
      end else begin
        exp_ray = expected_rays.pop_front();
        if (exp_ray.zero_length) zero_rays++;
        names = '{"origin_x", "origin_y", "origin_z", "dir_x", "dir_y", "dir_z",
                  "zero_length"};
        ev = '{exp_ray.origin_x, exp_ray.origin_y, exp_ray.origin_z, exp_ray.dir_x,
               exp_ray.dir_y, exp_ray.dir_z, exp_ray.zero_length};
        av = '{ray.data.origin_x, ray.data.origin_y, ray.data.origin_z, ray.data.dir_x,
               ray.data.dir_y, ray.data.dir_z, ray.data.zero_length};
        for (int i = 0; i < 7; i++) begin
          if (ev[i] !== av[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, names[i], ev[i], av[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    int st;
    st = ray_stall;
    if (ray_acc) st = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    else if (st > 0) st--;
    ray_stall <= st;
    ray.ready <= !rst && st == 0;
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_ORIGIN: cam_origin = value[47:0];
      REG_VIEW: cam_view = value[47:0];
      REG_RIGHT: cam_right = value[47:0];
      REG_UP: cam_up = value[47:0];
      REG_DIST: cam_dist = value[23:0];
      REG_PITCH: cam_pitch = value[23:0];
      REG_WIDTH: cam_width = value[12:0];
      REG_HEIGHT: cam_height = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pix.size() > 0 || expected_rays.size() > 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic queue_pix(int col, int row);
    pix_t p;
    p.pixel_col = 12'(col);
    p.pixel_row = 12'(row);
    pending_pix.push_back(p);
  endtask

  initial begin
    logic [47:0] v48;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.data = '0;
    ray.ready = 1'b0;
    cam_origin = 0;
    cam_view = 0;
    cam_right = 0;
    cam_up = 0;
    cam_dist = 4096;
    cam_pitch = 0;
    cam_width = 640;
    cam_height = 480;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setup has a zero basis: every ray is a zero vector
    queue_pix(0, 0);
    queue_pix(4095, 4095);
    queue_pix(320, 240);
    drain();

    write_reg(REG_ORIGIN, 48'h8000_7fff_0100);
    write_reg(REG_VIEW, {16'sd16384, 16'sd0, 16'sd0});
    write_reg(REG_RIGHT, {16'sd0, 16'sd0, 16'sd16384});
    write_reg(REG_UP, {16'sd0, 16'sd16384, 16'sd0});
    write_reg(REG_DIST, 24'd4096);
    write_reg(REG_PITCH, 24'd2048);
    write_reg(REG_WIDTH, 13'd640);
    write_reg(REG_HEIGHT, 13'd480);
    queue_pix(0, 0);
    queue_pix(639, 479);
    queue_pix(4095, 0);
    queue_pix(0, 4095);
    queue_pix(4095, 4095);
    queue_pix(320, 240);
    queue_pix(2730, 1365);
    drain();

    // extremes: most negative lanes, full distance and pitch, oversized dims
    write_reg(REG_ORIGIN, 48'hffff_ffff_ffff);
    write_reg(REG_VIEW, 48'h8000_8000_8000);
    write_reg(REG_RIGHT, 48'h7fff_8000_7fff);
    write_reg(REG_UP, 48'h8000_7fff_8000);
    write_reg(REG_DIST, 24'hffffff);
    write_reg(REG_PITCH, 24'hffffff);
    write_reg(REG_WIDTH, 13'h1fff);
    write_reg(REG_HEIGHT, 13'd4097);
    queue_pix(0, 0);
    queue_pix(4095, 4095);
    queue_pix(2048, 2047);
    queue_pix(0, 4095);
    drain();

    // one-pixel and zero dims, zero distance: the center pixel of a 1x1 image gives a zero vector
    write_reg(REG_DIST, 24'd0);
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd1);
    queue_pix(0, 0);
    queue_pix(1, 0);
    drain();
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    queue_pix(0, 0);
    queue_pix(4095, 4095);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < 8; i++) begin
        v48 = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0 && i >= REG_DIST && i <= REG_PITCH) v48 = 0;
        write_reg(i[IdxW-1:0], v48);
      end
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 1)) queue_pix($urandom_range(0, 4095), $urandom_range(0, 4095));
        else queue_pix($urandom_range(0, cam_width), $urandom_range(0, cam_height));
        if (phase == 3 && i == 30) begin
          @(posedge clk);
          hold = 1'b1;
          while (expected_rays.size() > 0 || pix.valid) @(posedge clk);
          hold = 1'b0;
        end
      end
      if (phase == 5) begin
        drain();
        for (int i = 0; i < 8; i++) write_reg(i[IdxW-1:0], {$urandom, $urandom});
      end
      drain();
    end

    $display("covered %0d ray words (%0d zero vectors) over directed and 8 random setups",
             rays_seen, zero_rays);
    if (errors == 0) $display("tb_primary_ray_generator_core: done, clean");
    else $display("tb_primary_ray_generator_core: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_primary_ray_generator_core: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/prg_pkg.sv
hw/rtl/prg_if.sv
hw/rtl/prg_isqrt.sv
hw/rtl/prg_qdiv.sv
hw/rtl/primary_ray_generator_core.sv
verif/tb_primary_ray_generator_core.sv
